>>> src/svdt_pkg.sv
// ----------------------------------------------------------------------------
// svdt_pkg: shared definitions for the sine voice with decay tail
// Widths, input codes, fixed-point constants and the elaboration-time
// quarter-wave sine table and note phase-step table.
// ----------------------------------------------------------------------------
package svdt_pkg;

	localparam int SAMPLE_RATE = 48000;
	localparam int SINE_DEPTH  = 1024;
	localparam int PHASE_BITS  = 32;

	localparam int IDX_BITS  = $clog2(SINE_DEPTH);
	localparam int QTR       = SINE_DEPTH / 4;
	localparam int QTR_BITS  = $clog2(QTR) + 1;
	localparam int NOTE_CNT  = 128;
	localparam int MAG_BITS  = 15;
	localparam int MUL_BITS  = 24;
	localparam int PROD_BITS = 2 * MUL_BITS;

	typedef enum logic [1:0] {
		KIND_TICK     = 2'd0,
		KIND_NOTE_ON  = 2'd1,
		KIND_OFF_TAIL = 2'd2,
		KIND_OFF_NOW  = 2'd3
	} kind_t;

	// Division of the velocity term by 5 and of the decay term by 100 are done
	// as multiplications by a rounded-up reciprocal; both are exact over the
	// value ranges that occur here.
	localparam logic [MUL_BITS-1:0] DIV5_RECIP   = 24'd52429;
	localparam int                  DIV5_SHIFT   = 18;
	localparam logic [MUL_BITS-1:0] DIV100_RECIP = 24'd10737419;
	localparam int                  DIV100_SHIFT = 30;
	localparam logic [MUL_BITS-1:0] DECAY_MUL    = 24'd99;
	localparam logic [22:0]         DECAY_ROUND  = 23'd50;
	localparam logic [18:0]         VEL_ROUND    = 19'd20;
	localparam logic [PROD_BITS-1:0] ROUND_HALF  = 48'd32768;
	localparam logic [16:0]         TAIL_ONE     = 17'd65536;
	localparam logic [16:0]         TAIL_STOP    = 17'd327;

	typedef struct packed {
		logic                neg;
		logic [MAG_BITS-1:0] mag;
	} wave_t;

	typedef logic [QTR:0][MAG_BITS-1:0]        qsine_tab_t;
	typedef logic [NOTE_CNT-1:0][PHASE_BITS-1:0] step_tab_t;

	localparam logic [31:0] NOTE_BASE_Q24 [12] = '{
		32'd137167144, 32'd145323527, 32'd153964914, 32'd163120144,
		32'd172819773, 32'd183096171, 32'd193983636, 32'd205518503,
		32'd217739269, 32'd230686720, 32'd244404066, 32'd258937088
	};

	// Q30 product truncated toward zero.
	function automatic longint mul_q30(longint a, longint b);
		longint t;
		t = a * b;
		if (t < 0) begin
			return -((-t) >>> 30);
		end
		return t >>> 30;
	endfunction

	// sin(pi/2 * x) for Q30 x in [0, 1.0], returned as Q15 in [0, 32767].
	function automatic logic [MAG_BITS-1:0] quarter_sine(longint x);
		longint x2;
		longint p;
		longint y;
		x2 = mul_q30(x, x);
		p  = 172272;
		p  = -5026995 + mul_q30(p, x2);
		p  = 85569306 + mul_q30(p, x2);
		p  = -693598668 + mul_q30(p, x2);
		p  = 1686629713 + mul_q30(p, x2);
		y  = mul_q30(p, x);
		if (y < 0) begin
			y = 0;
		end
		y = (y + 16384) >>> 15;
		if (y > 32767) begin
			y = 32767;
		end
		return y[MAG_BITS-1:0];
	endfunction

	function automatic qsine_tab_t build_qsine();
		qsine_tab_t t;
		for (int j = 0; j <= QTR; j++) begin
			t[j] = quarter_sine((longint'(j) <<< 30) / QTR);
		end
		return t;
	endfunction

	function automatic logic [PHASE_BITS-1:0] note_step(int note);
		longint unsigned f;
		longint unsigned q;
		longint unsigned r;
		longint unsigned h;
		int oct;
		int semi;
		int e;
		int steps;
		// Octave and semitone by repeated subtraction.
		oct  = 0;
		semi = note;
		while (semi >= 12) begin
			semi = semi - 12;
			oct  = oct + 1;
		end
		f     = longint'(NOTE_BASE_Q24[semi]);
		e     = oct + PHASE_BITS - 23;
		steps = (e > 0) ? e : 0;
		// Long division of f * 2^steps by the sample rate, one quotient bit per pass.
		q = 64'd0;
		r = 64'd0;
		for (int i = 0; i < 32 + steps; i++) begin
			r = r << 1;
			if (i < 32) begin
				r = r | ((f >> (31 - i)) & 64'd1);
			end
			q = q << 1;
			if (r >= SAMPLE_RATE) begin
				r = r - SAMPLE_RATE;
				q = q | 64'd1;
			end
		end
		if (e < 0) begin
			q = q >> (-e);
		end
		h = (q + 64'd1) >> 1;
		return h[PHASE_BITS-1:0];
	endfunction

	function automatic step_tab_t build_steps();
		step_tab_t t;
		for (int n = 0; n < NOTE_CNT; n++) begin
			t[n] = note_step(n);
		end
		return t;
	endfunction

	localparam qsine_tab_t QSINE    = build_qsine();
	localparam step_tab_t  STEP_TAB = build_steps();

endpackage

>>> src/svdt_mul.sv
// ----------------------------------------------------------------------------
// svdt_mul: shared unsigned multiplier
// The one multiplier of the voice; the sequencer feeds it a new operand pair
// in each step and registers the product it needs.
// ----------------------------------------------------------------------------
module svdt_mul
	import svdt_pkg::*;
(
	input  logic [MUL_BITS-1:0]  op_a,
	input  logic [MUL_BITS-1:0]  op_b,
	output logic [PROD_BITS-1:0] prod
);

	assign prod = PROD_BITS'(op_a) * PROD_BITS'(op_b);

endmodule

>>> src/svdt_wave.sv
// ----------------------------------------------------------------------------
// svdt_wave: sine lookup with registered output
// Folds the table index onto the quarter-wave table and returns the sign and
// magnitude of the Q15 sine sample in the next cycle.
// ----------------------------------------------------------------------------
module svdt_wave
	import svdt_pkg::*;
(
	input  logic                clk,
	input  logic [IDX_BITS-1:0] idx,
	output wave_t               wave
);

	logic [1:0]          quad;
	logic [IDX_BITS-3:0] pos;
	logic [QTR_BITS-1:0] qidx;

	assign quad = idx[IDX_BITS-1 -: 2];
	assign pos  = idx[IDX_BITS-3:0];

	// Odd quadrants run the quarter table backward.
	assign qidx = quad[0] ? (QTR_BITS'(QTR) - QTR_BITS'(pos)) : QTR_BITS'(pos);

	always_ff @(posedge clk) begin
		wave.neg <= quad[1];
		wave.mag <= QSINE[qidx];
	end

endmodule

>>> src/sine_voice_with_decay_tail_unit.sv
// ----------------------------------------------------------------------------
// sine_voice_with_decay_tail_unit: one sine oscillator voice with release tail
// Input words arrive on s_axis: tuser holds the kind (tick, note on, note off
// with tail, note off at once), tdata the note number and the velocity.
// Every input word yields exactly one output word on m_axis: the Q15 sample
// in tdata (zero for anything but a tick of a sounding voice) and the
// sounding flag in tuser.
// Words are handled one at a time by a small sequencer around one shared
// multiplier. The output word is loaded from the final step, which a note off
// or a silent tick reaches directly, a note on after one divide step, a tick
// without tail after one gain step, and a tick with a running tail after gain,
// tail, decay and divide steps. s_axis_tready is high only while the
// sequencer is idle, which it is again in the cycle after the load, so a new
// word is taken only after the last one has been loaded for output.
// The result sits in an output register; while the receiver stalls, the
// sequencer holds the next result in its last step and takes no new word.
// After reset the voice is silent with phase, level and tail at zero.
// ----------------------------------------------------------------------------
module sine_voice_with_decay_tail_unit
	import svdt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // note_number[6:0], note_velocity[22:7], zero pad
	input  logic [1:0]  s_axis_tuser,  // kind[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // sample_out[15:0]
	output logic        m_axis_tuser   // sounding
);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_NDIV  = 7'b0000010,
		ST_GAIN  = 7'b0000100,
		ST_TAIL  = 7'b0001000,
		ST_D99   = 7'b0010000,
		ST_DDIV  = 7'b0100000,
		ST_FIN   = 7'b1000000
	} state_t;

	state_t                state_q;
	logic [PHASE_BITS-1:0] phase_acc_q;
	logic [PHASE_BITS-1:0] phase_step_q;
	logic [15:0]           gain_q;
	logic [16:0]           tail_q;
	logic [MAG_BITS-1:0]   acc_q;
	logic [22:0]           num_q;
	logic                  tick_q;
	logic                  m_valid_q;
	logic [15:0]           m_data_q;
	logic                  m_user_q;

	logic                  in_acc;
	kind_t                 kind;
	logic [6:0]            note;
	logic [15:0]           vel;
	logic [18:0]           vel_term;
	wave_t                 wave;
	logic [MUL_BITS-1:0]   op_a;
	logic [MUL_BITS-1:0]   op_b;
	logic [PROD_BITS-1:0]  prod;
	logic [PROD_BITS-1:0]  prod_rnd;
	logic                  out_free;
	logic                  tail_stop;
	logic [15:0]           sample;

	assign kind   = kind_t'(s_axis_tuser);
	assign note   = s_axis_tdata[6:0];
	assign vel    = s_axis_tdata[22:7];
	assign in_acc = s_axis_tvalid && s_axis_tready;

	assign s_axis_tready = (state_q == ST_IDLE);

	// Level is round(vel * 3 / 20): (vel * 6 + 20) / 8 here, then / 5 by reciprocal.
	assign vel_term = (19'(vel) << 2) + (19'(vel) << 1) + VEL_ROUND;

	svdt_wave u_wave (
		.clk  (clk),
		.idx  (phase_acc_q[PHASE_BITS-1 -: IDX_BITS]),
		.wave (wave)
	);

	always_comb begin
		op_a = '0;
		op_b = '0;
		case (state_q)
			ST_NDIV: begin
				op_a = MUL_BITS'(num_q);
				op_b = DIV5_RECIP;
			end
			ST_GAIN: begin
				op_a = MUL_BITS'(wave.mag);
				op_b = MUL_BITS'(gain_q);
			end
			ST_TAIL: begin
				op_a = MUL_BITS'(acc_q);
				op_b = MUL_BITS'(tail_q);
			end
			ST_D99: begin
				op_a = MUL_BITS'(tail_q);
				op_b = DECAY_MUL;
			end
			ST_DDIV: begin
				op_a = MUL_BITS'(num_q);
				op_b = DIV100_RECIP;
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	svdt_mul u_mul (
		.op_a (op_a),
		.op_b (op_b),
		.prod (prod)
	);

	assign prod_rnd  = prod + ROUND_HALF;
	assign out_free  = !m_valid_q || m_axis_tready;
	assign tail_stop = (tail_q != '0) && (tail_q <= TAIL_STOP);
	assign sample    = wave.neg ? (16'd0 - 16'(acc_q)) : 16'(acc_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			phase_acc_q  <= '0;
			phase_step_q <= '0;
			gain_q       <= '0;
			tail_q       <= '0;
			acc_q        <= '0;
			num_q        <= '0;
			tick_q       <= 1'b0;
			m_valid_q    <= 1'b0;
		end else begin
			m_valid_q <= (state_q == ST_FIN && out_free) || (m_valid_q && !m_axis_tready);
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						tick_q <= (kind == KIND_TICK) && (phase_step_q != '0);
						case (kind)
							KIND_NOTE_ON: begin
								phase_acc_q  <= '0;
								tail_q       <= '0;
								phase_step_q <= STEP_TAB[note];
								num_q        <= 23'(vel_term[18:3]);
								state_q      <= ST_NDIV;
							end
							KIND_OFF_TAIL: begin
								if (tail_q == '0) begin
									tail_q <= TAIL_ONE;
								end
								state_q <= ST_FIN;
							end
							KIND_OFF_NOW: begin
								phase_step_q <= '0;
								state_q      <= ST_FIN;
							end
							default: begin
								state_q <= (phase_step_q != '0) ? ST_GAIN : ST_FIN;
							end
						endcase
					end
				end
				ST_NDIV: begin
					gain_q  <= prod[DIV5_SHIFT +: 16];
					state_q <= ST_FIN;
				end
				ST_GAIN: begin
					acc_q   <= prod_rnd[16 +: MAG_BITS];
					state_q <= (tail_q != '0) ? ST_TAIL : ST_FIN;
				end
				ST_TAIL: begin
					acc_q   <= prod_rnd[16 +: MAG_BITS];
					state_q <= ST_D99;
				end
				ST_D99: begin
					num_q   <= prod[22:0] + DECAY_ROUND;
					state_q <= ST_DDIV;
				end
				ST_DDIV: begin
					tail_q  <= prod[DIV100_SHIFT +: 17];
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						if (tick_q) begin
							phase_acc_q <= phase_acc_q + phase_step_q;
							if (tail_stop) begin
								phase_step_q <= '0;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output word payload.
	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			m_data_q <= tick_q ? sample : '0;
			m_user_q <= (phase_step_q != '0) && !(tick_q && tail_stop);
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

endmodule

>>> dv/svdt_voice_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svdt_voice_checker: result predictor and scoreboard for the sine voice
// Watches both stream channels of the voice. Each accepted input word is run
// through an independent model of the oscillator, level, tail and decay, and
// the expected output word is queued. Each accepted output word is compared
// field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module svdt_voice_checker
	import svdt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // note_number[6:0], note_velocity[22:7], zero pad
	input  logic [1:0]  s_axis_tuser,  // kind[1:0]
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [15:0] m_axis_tdata,  // sample_out[15:0]
	input  logic        m_axis_tuser,  // sounding
	output int          fail_count,
	output int          pending
);

	localparam int     WAVE_LEN  = 1024;
	localparam int     WAVE_BITS = 10;
	localparam int     PHASE_W   = 32;
	localparam int     RATE_HZ   = 48000;
	localparam longint Q30_ONE   = 64'sd1073741824;

	// Q24 frequencies of the lowest octave, MIDI notes 0 to 11.
	localparam longint unsigned NOTE_HZ_Q24 [12] = '{
		137167144, 145323527, 153964914, 163120144,
		172819773, 183096171, 193983636, 205518503,
		217739269, 230686720, 244404066, 258937088
	};

	typedef struct packed {
		logic [15:0] sample;
		logic        sounding;
	} voice_sample_t;

	int            sine_q15 [WAVE_LEN];
	logic [31:0]   osc_phase;
	logic [31:0]   osc_step;
	logic [15:0]   level_q16;
	logic [16:0]   tail_q16;
	voice_sample_t expected_samples [$];

	function automatic longint qmul30(longint a, longint b);
		return (a * b) / Q30_ONE;
	endfunction

	// sin(pi/2 * x) for Q30 x, odd polynomial up to x^9, rounded to Q15.
	function automatic int quarter_wave(longint x);
		longint x2;
		longint p;
		longint y;
		x2 = qmul30(x, x);
		p = 172272;
		p = -5026995 + qmul30(p, x2);
		p = 85569306 + qmul30(p, x2);
		p = -693598668 + qmul30(p, x2);
		p = 1686629713 + qmul30(p, x2);
		y = qmul30(p, x);
		if (y < 0) begin
			y = 0;
		end
		y = (y + 16384) / 32768;
		if (y > 32767) begin
			y = 32767;
		end
		return int'(y);
	endfunction

	// Round-half-up of f * 2^32 / rate, done as a long division by shifting.
	function automatic logic [31:0] note_phase_step(logic [6:0] note);
		longint unsigned f;
		longint unsigned q;
		longint unsigned r;
		longint unsigned h;
		int              e;
		f = NOTE_HZ_Q24[note % 12];
		e = int'(note / 12) + PHASE_W - 23;
		r = f % RATE_HZ;
		q = f / RATE_HZ;
		for (int i = 0; i < e; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= RATE_HZ) begin
				r = r - RATE_HZ;
				q = q | 64'd1;
			end
		end
		h = (q + 64'd1) >> 1;
		return h[31:0];
	endfunction

	function automatic voice_sample_t step_voice(kind_t kind, logic [6:0] note,
		logic [15:0] vel);
		voice_sample_t res;
		longint        s;
		longint        mag;
		longint        v;
		v = 0;
		case (kind)
			KIND_NOTE_ON: begin
				osc_phase = '0;
				level_q16 = 16'((32'(vel) * 6 + 20) / 40);
				tail_q16  = '0;
				osc_step  = note_phase_step(note);
			end
			KIND_OFF_TAIL: begin
				if (tail_q16 == '0) begin
					tail_q16 = 17'd65536;
				end
			end
			KIND_OFF_NOW: begin
				osc_step = '0;
			end
			default: begin
				if (osc_step != '0) begin
					s   = sine_q15[osc_phase >> (PHASE_W - WAVE_BITS)];
					mag = (s < 0) ? -s : s;
					mag = (mag * longint'(level_q16) + 32768) >>> 16;
					if (tail_q16 != '0) begin
						mag = (mag * longint'(tail_q16) + 32768) >>> 16;
					end
					v = (s < 0) ? -mag : mag;
					osc_phase = osc_phase + osc_step;
					if (tail_q16 != '0) begin
						tail_q16 = 17'((32'(tail_q16) * 99 + 50) / 100);
						if (tail_q16 <= 17'd327) begin
							osc_step = '0;
						end
					end
				end
			end
		endcase
		res.sample   = v[15:0];
		res.sounding = (osc_step != '0);
		return res;
	endfunction

	task automatic report_mismatch(string what, int want, int got);
		$display("%0t ns: mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
		fail_count++;
	endtask

	initial begin
		int quad;
		int rem;
		int frac;
		int mag;
		fail_count = 0;
		pending = 0;
		// Full-turn table from the quarter wave: mirror in odd quadrants,
		// negate in the second half.
		for (int i = 0; i < WAVE_LEN; i++) begin
			quad = (i * 4) / WAVE_LEN;
			rem  = (i * 4) % WAVE_LEN;
			frac = (quad % 2 == 1) ? WAVE_LEN - rem : rem;
			mag  = quarter_wave((longint'(frac) <<< 30) / WAVE_LEN);
			sine_q15[i] = (quad >= 2) ? -mag : mag;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		voice_sample_t want;
		if (!arst_n) begin
			osc_phase = '0;
			osc_step  = '0;
			level_q16 = '0;
			tail_q16  = '0;
			expected_samples.delete();
		end else begin
			// Outputs are checked before the new input is predicted, so a word
			// leaving on the same edge is matched against older work.
			if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
				if (expected_samples.size() == 0) begin
					report_mismatch("output word with none expected", 0,
						int'($signed(m_axis_tdata)));
				end else begin
					want = expected_samples.pop_front();
					if (m_axis_tdata !== want.sample) begin
						report_mismatch("sample_out", int'($signed(want.sample)),
							int'($signed(m_axis_tdata)));
					end
					if (m_axis_tuser !== want.sounding) begin
						report_mismatch("sounding", int'(want.sounding), int'(m_axis_tuser));
					end
				end
			end
			if (s_axis_tvalid === 1'b1 && s_axis_tready === 1'b1) begin
				expected_samples.push_back(step_voice(kind_t'(s_axis_tuser),
					s_axis_tdata[6:0], s_axis_tdata[22:7]));
			end
		end
		pending = expected_samples.size();
	end

endmodule

>>> dv/sine_voice_with_decay_tail_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sine_voice_with_decay_tail_unit_tb: top-level testbench for the sine voice
// Drives note on, note off and tick words into the voice: a short directed
// opening, then random note sequences with tails, hard stops, runs to full
// silence and noise, with random idling on both sides of the stream.
// A separate checker predicts and compares every output word.
// ----------------------------------------------------------------------------
module sine_voice_with_decay_tail_unit_tb
	import svdt_pkg::*;
();

	localparam int TOTAL_WORDS = 900;
	localparam int CALM_FROM   = 800;
	localparam int LONG_HOLD   = 300;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;
	logic [1:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;
	logic        m_axis_tuser;
	int          fail_count;
	int          pending;

	bit          calm = 1'b0;
	bit          stall_long = 1'b0;
	int          words_sent = 0;

	always #4 clk = ~clk;

	sine_voice_with_decay_tail_unit DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	svdt_voice_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	task automatic send_word(input kind_t kind, input logic [6:0] note, input logic [15:0] vel);
		if (!calm && $urandom_range(4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(15, 1)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= kind;
		s_axis_tdata  <= {1'b0, vel, note};
		do @(posedge clk); while (s_axis_tready !== 1'b1);
		words_sent++;
	endtask

	// Ticks carry random bits in the fields they do not use.
	task automatic tick_run(input int count);
		repeat (count) send_word(KIND_TICK, 7'($urandom_range(127)), 16'($urandom_range(65535)));
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
	endtask

	// Receiver: random stalls, a long hold-off on request, none at the end.
	initial begin
		forever begin
			if (stall_long) begin
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				stall_long = 1'b0;
			end else if (!calm && $urandom_range(3) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(15, 1)) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				repeat ($urandom_range(20, 1)) @(posedge clk);
			end
		end
	end

	initial begin
		#3_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		int  seq_count;
		int  pick;
		bit  full_release;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= KIND_TICK;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Silent voice: tick, tail armed with no sound, hard stop.
		send_word(KIND_TICK, 7'd0, 16'd0);
		send_word(KIND_OFF_TAIL, 7'd0, 16'd0);
		send_word(KIND_OFF_NOW, 7'd127, 16'hFFFF);
		// Lowest note at full velocity; note on clears the armed tail.
		send_word(KIND_NOTE_ON, 7'd0, 16'hFFFF);
		tick_run(3);
		// Highest note at zero velocity sounds with zero level.
		send_word(KIND_NOTE_ON, 7'd127, 16'h0000);
		tick_run(2);
		send_word(KIND_NOTE_ON, 7'd69, 16'h8000);
		tick_run(2);
		send_word(KIND_OFF_TAIL, 7'd0, 16'd0);
		tick_run(3);
		// A second tail request while one runs leaves it alone.
		send_word(KIND_OFF_TAIL, 7'd0, 16'd0);
		tick_run(1);
		send_word(KIND_OFF_NOW, 7'd0, 16'd0);
		tick_run(1);
		send_word(KIND_NOTE_ON, 7'd60, 16'h7FFF);
		tick_run(1);
		send_word(KIND_NOTE_ON, 7'd127, 16'hFFFF);
		tick_run(2);

		seq_count = 0;
		full_release = 1'b0;
		while (words_sent < TOTAL_WORDS) begin
			seq_count++;
			if (words_sent >= CALM_FROM) begin
				calm = 1'b1;
			end
			// The block stalls its input while the receiver holds off.
			if (seq_count == 8) begin
				stall_long = 1'b1;
			end
			if (seq_count == 14) begin
				drain_results();
			end
			pick = $urandom_range(9);
			if (pick == 0) begin
				repeat ($urandom_range(6, 1)) begin
					send_word(kind_t'($urandom_range(3)), 7'($urandom_range(127)),
						16'($urandom_range(65535)));
				end
			end else begin
				send_word(KIND_NOTE_ON, 7'($urandom_range(127)), 16'($urandom_range(65535)));
				tick_run($urandom_range(30, 1));
				pick = $urandom_range(5);
				if (pick <= 2) begin
					send_word(KIND_OFF_TAIL, 7'($urandom_range(127)), 16'($urandom_range(65535)));
					// Once the tail runs all the way down to silence.
					if (!full_release && words_sent > 300) begin
						tick_run(560);
						full_release = 1'b1;
					end else begin
						tick_run($urandom_range(40));
						if ($urandom_range(3) == 0) begin
							send_word(KIND_OFF_TAIL, 7'd0, 16'd0);
							tick_run($urandom_range(10));
						end
					end
				end else if (pick == 3) begin
					send_word(KIND_OFF_NOW, 7'($urandom_range(127)), 16'($urandom_range(65535)));
					tick_run($urandom_range(3));
				end
			end
		end

		drain_results();
		repeat (16) @(posedge clk);
		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
